[src/amacd_pkg.sv]
// Types, codes and the per-character accumulator update for the ASCII
// motor/arm command decoder.
// No dependencies.
package amacd_pkg;

    localparam int CmdW   = 8;
    localparam int MagW   = 10;
    localparam int AngleW = 11;
    localparam int Slices = 5;
    localparam int CfgIdxW = 2;

    localparam logic [MagW-1:0] MagCap   = 10'd1023;
    localparam logic [7:0]      SpaceChr = 8'd32;
    localparam logic [7:0]      NulChr   = 8'd0;
    localparam logic [7:0]      PlusChr  = 8'd43;
    localparam logic [7:0]      MinusChr = 8'd45;
    localparam logic [7:0]      ZeroChr  = 8'd48;
    localparam logic [7:0]      NineChr  = 8'd57;
    localparam logic [7:0]      MotorSat = 8'd255;

    localparam logic [7:0] MotorLetterRst = 8'd111;
    localparam logic [7:0] ArmLetterRst   = 8'd97;
    localparam logic [7:0] EndByteRst     = 8'd118;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] CfgMotorLetter = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgArmLetter   = 2'd1;
    localparam logic [CfgIdxW-1:0] CfgEndByte     = 2'd2;

    // result kinds
    localparam logic [1:0] KindMotor   = 2'd0;
    localparam logic [1:0] KindArm     = 2'd1;
    localparam logic [1:0] KindInvalid = 2'd2;

    typedef enum logic [1:0] {
        PH_CMD  = 2'd0,
        PH_ARG1 = 2'd1,
        PH_ARG2 = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        SCAN_LEAD   = 2'd0,
        SCAN_DIGITS = 2'd1,
        SCAN_DONE   = 2'd2
    } scan_t;

    typedef struct packed {
        scan_t           scan;
        logic            neg;
        logic [MagW-1:0] mag;
    } acc_t;

    localparam acc_t AccClear = '{scan: SCAN_LEAD, neg: 1'b0, mag: '0};

    function automatic logic is_blank(input logic [7:0] c);
        return (c == SpaceChr) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    // atoi-style streaming update: leading blanks, optional sign, digits
    function automatic acc_t acc_feed(input acc_t a, input logic [7:0] c);
        acc_t        r;
        logic        digit;
        logic        take;
        logic [13:0] prod;
        r     = a;
        digit = (c >= ZeroChr) && (c <= NineChr);
        take  = 1'b0;
        case (a.scan)
            SCAN_LEAD:
            begin
                if (is_blank(c))
                begin
                    take = 1'b0;
                end
                else if (c == PlusChr || c == MinusChr)
                begin
                    r.neg  = (c == MinusChr);
                    r.scan = SCAN_DIGITS;
                end
                else if (!digit)
                begin
                    r.scan = SCAN_DONE;
                end
                else
                begin
                    r.scan = SCAN_DIGITS;
                    take   = 1'b1;
                end
            end
            SCAN_DIGITS:
            begin
                if (digit)
                begin
                    take = 1'b1;
                end
                else
                begin
                    r.scan = SCAN_DONE;
                end
            end
            default:
            begin
                take = 1'b0;
            end
        endcase
        // mag * 10 + digit, saturated
        prod = ({4'd0, a.mag} << 3) + ({4'd0, a.mag} << 1) + {10'd0, c[3:0]};
        if (take)
        begin
            r.mag = (prod > {4'd0, MagCap}) ? MagCap : prod[MagW-1:0];
        end
        return r;
    endfunction

    function automatic logic [AngleW-1:0] acc_signed(input acc_t a);
        logic [AngleW-1:0] m;
        m = {1'b0, a.mag};
        return a.neg ? (~m + 1'b1) : m;
    endfunction

endpackage

[src/ascii_motor_arm_command_decoder.sv]
// Top level of the ASCII motor/arm command decoder: line parser state,
// streaming argument accumulators and the registered result.
// Depends on amacd_pkg.
// A terminator byte's result is registered at the clock edge that accepts the byte.
// Throughput: one byte per cycle; input stalls only while a result is held and
// the output side stalls. Other bytes give no result.
// Reset: asynchronous, active low; clears the parser state, restores the command
// letters and terminator to their defaults and empties the result register.
module ascii_motor_arm_command_decoder #(
    parameter int ARG_CHARS = 15
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [amacd_pkg::CfgIdxW-1:0]     cfg_index,
    input  logic [7:0]                        cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [7:0]                        rx_byte,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [1:0]                        result_kind,
    output logic [7:0]                        left_magnitude,
    output logic                              left_reverse,
    output logic [7:0]                        right_magnitude,
    output logic                              right_reverse,
    output logic signed [amacd_pkg::AngleW-1:0] waist_target,
    output logic signed [amacd_pkg::AngleW-1:0] shoulder_target,
    output logic signed [amacd_pkg::AngleW-1:0] elbow_target,
    output logic signed [amacd_pkg::AngleW-1:0] wrist_target,
    output logic signed [amacd_pkg::AngleW-1:0] gripper_target
);

    localparam int PosW = $clog2(ARG_CHARS + 1);
    localparam logic [PosW-1:0] PosLimit = PosW'(ARG_CHARS);

    // configuration
    logic [7:0] motor_letter_reg;
    logic [7:0] arm_letter_reg;
    logic [7:0] end_byte_reg;

    // parser state
    amacd_pkg::phase_t phase_reg, phase_next;
    logic [PosW-1:0]   pos_reg, pos_next;
    logic [2:0]        slice_idx_reg, slice_idx_next;
    logic [1:0]        slice_sub_reg, slice_sub_next;
    logic [7:0]        cmd_reg, cmd_next;
    amacd_pkg::acc_t   arg1_reg, arg1_next;
    amacd_pkg::acc_t   arg2_reg, arg2_next;
    amacd_pkg::acc_t   slice_reg [amacd_pkg::Slices];
    amacd_pkg::acc_t   slice_next [amacd_pkg::Slices];

    // result register
    logic                             out_valid_reg, out_valid_next;
    logic [1:0]                       kind_reg, kind_next;
    logic [7:0]                       lmag_reg, lmag_next;
    logic                             lrev_reg, lrev_next;
    logic [7:0]                       rmag_reg, rmag_next;
    logic                             rrev_reg, rrev_next;
    logic [amacd_pkg::AngleW-1:0]     angle_reg [amacd_pkg::Slices];
    logic [amacd_pkg::AngleW-1:0]     angle_next [amacd_pkg::Slices];

    logic in_take;
    logic is_end;
    logic is_space;
    logic arg_open;

    assign in_stall = out_valid_reg & out_stall;
    assign in_take  = in_valid & ~in_stall;
    assign is_end   = (rx_byte == end_byte_reg);
    assign is_space = (rx_byte == amacd_pkg::SpaceChr);
    assign arg_open = (pos_reg < PosLimit);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            motor_letter_reg <= amacd_pkg::MotorLetterRst;
            arm_letter_reg   <= amacd_pkg::ArmLetterRst;
            end_byte_reg     <= amacd_pkg::EndByteRst;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                amacd_pkg::CfgMotorLetter: motor_letter_reg <= cfg_data;
                amacd_pkg::CfgArmLetter:   arm_letter_reg   <= cfg_data;
                amacd_pkg::CfgEndByte:     end_byte_reg     <= cfg_data;
                default:                   motor_letter_reg <= motor_letter_reg;
            endcase
        end
    end

    // phase sequencing
    always_comb
    begin
        phase_next = phase_reg;
        if (in_take)
        begin
            if (is_end)
            begin
                phase_next = amacd_pkg::PH_CMD;
            end
            else if (is_space)
            begin
                case (phase_reg)
                    amacd_pkg::PH_CMD:  phase_next = amacd_pkg::PH_ARG1;
                    amacd_pkg::PH_ARG1: phase_next = amacd_pkg::PH_ARG2;
                    default:            phase_next = phase_reg;
                endcase
            end
        end
    end

    // accumulators and character counters
    always_comb
    begin
        pos_next       = pos_reg;
        slice_idx_next = slice_idx_reg;
        slice_sub_next = slice_sub_reg;
        cmd_next       = cmd_reg;
        arg1_next      = arg1_reg;
        arg2_next      = arg2_reg;
        for (int k = 0; k < amacd_pkg::Slices; k++)
        begin
            slice_next[k] = slice_reg[k];
        end
        if (in_take)
        begin
            if (is_end)
            begin
                pos_next       = '0;
                slice_idx_next = '0;
                slice_sub_next = '0;
                cmd_next       = '0;
                arg1_next      = amacd_pkg::AccClear;
                arg2_next      = amacd_pkg::AccClear;
                for (int k = 0; k < amacd_pkg::Slices; k++)
                begin
                    slice_next[k] = amacd_pkg::AccClear;
                end
            end
            else if (is_space)
            begin
                if (phase_reg == amacd_pkg::PH_ARG1)
                begin
                    pos_next = '0;
                end
            end
            else if (phase_reg == amacd_pkg::PH_CMD)
            begin
                cmd_next = rx_byte;
            end
            else if (arg_open)
            begin
                if (rx_byte == amacd_pkg::NulChr)
                begin
                    // NUL closes the argument text
                    pos_next = PosLimit;
                end
                else
                begin
                    pos_next = pos_reg + 1'b1;
                    if (phase_reg == amacd_pkg::PH_ARG1)
                    begin
                        arg1_next = amacd_pkg::acc_feed(arg1_reg, rx_byte);
                        for (int k = 0; k < amacd_pkg::Slices; k++)
                        begin
                            if (slice_idx_reg == 3'(k))
                            begin
                                slice_next[k] = amacd_pkg::acc_feed(slice_reg[k], rx_byte);
                            end
                        end
                        // three characters per slice; index stops past the last
                        if (slice_sub_reg == 2'd2)
                        begin
                            slice_sub_next = '0;
                            if (slice_idx_reg < 3'(amacd_pkg::Slices))
                            begin
                                slice_idx_next = slice_idx_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            slice_sub_next = slice_sub_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        arg2_next = amacd_pkg::acc_feed(arg2_reg, rx_byte);
                    end
                end
            end
        end
    end

    // result formation on the terminator
    always_comb
    begin
        out_valid_next = out_valid_reg & out_stall;
        kind_next      = kind_reg;
        lmag_next      = lmag_reg;
        lrev_next      = lrev_reg;
        rmag_next      = rmag_reg;
        rrev_next      = rrev_reg;
        for (int k = 0; k < amacd_pkg::Slices; k++)
        begin
            angle_next[k] = angle_reg[k];
        end
        if (in_take && is_end)
        begin
            out_valid_next = 1'b1;
            kind_next      = amacd_pkg::KindInvalid;
            lmag_next      = '0;
            lrev_next      = 1'b0;
            rmag_next      = '0;
            rrev_next      = 1'b0;
            for (int k = 0; k < amacd_pkg::Slices; k++)
            begin
                angle_next[k] = '0;
            end
            if (cmd_reg == motor_letter_reg)
            begin
                kind_next = amacd_pkg::KindMotor;
                lmag_next = (arg1_reg.mag > 10'(amacd_pkg::MotorSat)) ?
                            amacd_pkg::MotorSat : arg1_reg.mag[7:0];
                rmag_next = (arg2_reg.mag > 10'(amacd_pkg::MotorSat)) ?
                            amacd_pkg::MotorSat : arg2_reg.mag[7:0];
                lrev_next = arg1_reg.neg & (arg1_reg.mag != '0);
                rrev_next = arg2_reg.neg & (arg2_reg.mag != '0);
            end
            else if (cmd_reg == arm_letter_reg)
            begin
                kind_next = amacd_pkg::KindArm;
                for (int k = 0; k < amacd_pkg::Slices; k++)
                begin
                    angle_next[k] = amacd_pkg::acc_signed(slice_reg[k]);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= amacd_pkg::PH_CMD;
            pos_reg       <= '0;
            slice_idx_reg <= '0;
            slice_sub_reg <= '0;
            cmd_reg       <= '0;
            arg1_reg      <= amacd_pkg::AccClear;
            arg2_reg      <= amacd_pkg::AccClear;
            for (int k = 0; k < amacd_pkg::Slices; k++)
            begin
                slice_reg[k] <= amacd_pkg::AccClear;
            end
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            slice_idx_reg <= slice_idx_next;
            slice_sub_reg <= slice_sub_next;
            cmd_reg       <= cmd_next;
            arg1_reg      <= arg1_next;
            arg2_reg      <= arg2_next;
            for (int k = 0; k < amacd_pkg::Slices; k++)
            begin
                slice_reg[k] <= slice_next[k];
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, no reset
    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        lmag_reg <= lmag_next;
        lrev_reg <= lrev_next;
        rmag_reg <= rmag_next;
        rrev_reg <= rrev_next;
        for (int k = 0; k < amacd_pkg::Slices; k++)
        begin
            angle_reg[k] <= angle_next[k];
        end
    end

    assign out_valid       = out_valid_reg;
    assign result_kind     = kind_reg;
    assign left_magnitude  = lmag_reg;
    assign left_reverse    = lrev_reg;
    assign right_magnitude = rmag_reg;
    assign right_reverse   = rrev_reg;
    assign waist_target    = angle_reg[0];
    assign shoulder_target = angle_reg[1];
    assign elbow_target    = angle_reg[2];
    assign wrist_target    = angle_reg[3];
    assign gripper_target  = angle_reg[4];

endmodule

[tb/amacd_result_checker.sv]
// Result checker for the ASCII motor/arm command decoder: follows register writes
// and accepted request bytes, predicts each command result and compares it.
// Depends on amacd_pkg.
module amacd_result_checker #(
    parameter int ARG_CHARS = 15
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [amacd_pkg::CfgIdxW-1:0]       cfg_index,
    input  logic [7:0]                          cfg_data,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic [7:0]                          rx_byte,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic [1:0]                          result_kind,
    input  logic [7:0]                          left_magnitude,
    input  logic                                left_reverse,
    input  logic [7:0]                          right_magnitude,
    input  logic                                right_reverse,
    input  logic signed [amacd_pkg::AngleW-1:0] waist_target,
    input  logic signed [amacd_pkg::AngleW-1:0] shoulder_target,
    input  logic signed [amacd_pkg::AngleW-1:0] elbow_target,
    input  logic signed [amacd_pkg::AngleW-1:0] wrist_target,
    input  logic signed [amacd_pkg::AngleW-1:0] gripper_target,
    output int                                  mismatch_count,
    output int                                  pending_count
);

    localparam int         ReportLimit = 10;
    localparam logic [7:0] TabChr      = 8'd9;
    localparam logic [7:0] CrChr       = 8'd13;

    typedef struct packed {
        amacd_pkg::scan_t           scan;
        logic                       neg;
        logic [amacd_pkg::MagW-1:0] mag;
    } number_scan_t;

    typedef struct packed {
        logic [1:0]                   kind;
        logic [7:0]                   left_mag;
        logic                         left_rev;
        logic [7:0]                   right_mag;
        logic                         right_rev;
        logic [amacd_pkg::AngleW-1:0] waist;
        logic [amacd_pkg::AngleW-1:0] shoulder;
        logic [amacd_pkg::AngleW-1:0] elbow;
        logic [amacd_pkg::AngleW-1:0] wrist;
        logic [amacd_pkg::AngleW-1:0] gripper;
    } command_result_t;

    localparam number_scan_t ScanIdle = '{scan: amacd_pkg::SCAN_LEAD, neg: 1'b0, mag: '0};

    logic [7:0]          motor_letter;
    logic [7:0]          arm_letter;
    logic [7:0]          end_letter;
    amacd_pkg::phase_t   line_phase;
    int                  arg_count;
    logic [7:0]          cmd_byte;
    number_scan_t        left_num;
    number_scan_t        right_num;
    number_scan_t        slice_num [amacd_pkg::Slices];
    command_result_t     expected_results [$];
    command_result_t     got;
    command_result_t     want;

    // atoi-like: blanks, optional sign, digits until the first other character
    function automatic number_scan_t scan_char(input number_scan_t a, input logic [7:0] c);
        number_scan_t r;
        logic         is_digit;
        int           grown;
        r        = a;
        is_digit = (c >= amacd_pkg::ZeroChr) && (c <= amacd_pkg::NineChr);
        if (a.scan == amacd_pkg::SCAN_DONE)
        begin
            return r;
        end
        if (a.scan == amacd_pkg::SCAN_LEAD)
        begin
            if (c == amacd_pkg::SpaceChr || (c >= TabChr && c <= CrChr))
            begin
                return r;
            end
            if (c == amacd_pkg::PlusChr || c == amacd_pkg::MinusChr)
            begin
                r.neg  = (c == amacd_pkg::MinusChr);
                r.scan = amacd_pkg::SCAN_DIGITS;
                return r;
            end
            if (!is_digit)
            begin
                r.scan = amacd_pkg::SCAN_DONE;
                return r;
            end
            r.scan = amacd_pkg::SCAN_DIGITS;
        end
        else if (!is_digit)
        begin
            r.scan = amacd_pkg::SCAN_DONE;
            return r;
        end
        grown = int'(a.mag) * 10 + int'(c - amacd_pkg::ZeroChr);
        r.mag = (grown > int'(amacd_pkg::MagCap)) ? amacd_pkg::MagCap
                                                  : grown[amacd_pkg::MagW-1:0];
        return r;
    endfunction

    function automatic logic [amacd_pkg::AngleW-1:0] angle_of(input number_scan_t a);
        logic [amacd_pkg::AngleW-1:0] m;
        m = {1'b0, a.mag};
        return a.neg ? -m : m;
    endfunction

    function automatic logic [7:0] motor_mag(input number_scan_t a);
        return (a.mag > 10'd255) ? amacd_pkg::MotorSat : a.mag[7:0];
    endfunction

    function automatic string describe_result(input command_result_t r);
        return $sformatf("kind %0d left %0d/%0b right %0d/%0b angles %0d %0d %0d %0d %0d",
                         r.kind, r.left_mag, r.left_rev, r.right_mag, r.right_rev,
                         $signed(r.waist), $signed(r.shoulder), $signed(r.elbow),
                         $signed(r.wrist), $signed(r.gripper));
    endfunction

    task automatic clear_line();
        line_phase = amacd_pkg::PH_CMD;
        arg_count  = 0;
        cmd_byte   = '0;
        left_num   = ScanIdle;
        right_num  = ScanIdle;
        for (int k = 0; k < amacd_pkg::Slices; k++)
        begin
            slice_num[k] = ScanIdle;
        end
    endtask

    task automatic take_byte(input logic [7:0] c);
        command_result_t r;
        int              k;
        if (c == end_letter)
        begin
            r = '0;
            // motor letter wins when both letters are the same
            if (cmd_byte == motor_letter)
            begin
                r.kind      = amacd_pkg::KindMotor;
                r.left_mag  = motor_mag(left_num);
                r.left_rev  = left_num.neg && (left_num.mag != '0);
                r.right_mag = motor_mag(right_num);
                r.right_rev = right_num.neg && (right_num.mag != '0);
            end
            else if (cmd_byte == arm_letter)
            begin
                r.kind     = amacd_pkg::KindArm;
                r.waist    = angle_of(slice_num[0]);
                r.shoulder = angle_of(slice_num[1]);
                r.elbow    = angle_of(slice_num[2]);
                r.wrist    = angle_of(slice_num[3]);
                r.gripper  = angle_of(slice_num[4]);
            end
            else
            begin
                r.kind = amacd_pkg::KindInvalid;
            end
            expected_results.push_back(r);
            clear_line();
        end
        else if (c == amacd_pkg::SpaceChr)
        begin
            if (line_phase == amacd_pkg::PH_CMD)
            begin
                line_phase = amacd_pkg::PH_ARG1;
            end
            else if (line_phase == amacd_pkg::PH_ARG1)
            begin
                line_phase = amacd_pkg::PH_ARG2;
                arg_count  = 0;
            end
        end
        else if (line_phase == amacd_pkg::PH_CMD)
        begin
            cmd_byte = c;
        end
        else if (arg_count < ARG_CHARS)
        begin
            if (c == amacd_pkg::NulChr)
            begin
                // NUL closes the argument text
                arg_count = ARG_CHARS;
            end
            else
            begin
                if (line_phase == amacd_pkg::PH_ARG1)
                begin
                    left_num = scan_char(left_num, c);
                    k = arg_count / 3;
                    if (k < amacd_pkg::Slices)
                    begin
                        slice_num[k] = scan_char(slice_num[k], c);
                    end
                end
                else
                begin
                    right_num = scan_char(right_num, c);
                end
                arg_count++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            motor_letter   = amacd_pkg::MotorLetterRst;
            arm_letter     = amacd_pkg::ArmLetterRst;
            end_letter     = amacd_pkg::EndByteRst;
            mismatch_count = 0;
            expected_results.delete();
            clear_line();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got = {result_kind, left_magnitude, left_reverse, right_magnitude,
                       right_reverse, waist_target, shoulder_target, elbow_target,
                       wrist_target, gripper_target};
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= ReportLimit)
                    begin
                        $display("unexpected result: %s", describe_result(got));
                    end
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= ReportLimit)
                        begin
                            $display("bad result: expected %s", describe_result(want));
                            $display("            got      %s", describe_result(got));
                        end
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                take_byte(rx_byte);
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    amacd_pkg::CfgMotorLetter: motor_letter = cfg_data;
                    amacd_pkg::CfgArmLetter:   arm_letter   = cfg_data;
                    amacd_pkg::CfgEndByte:     end_letter   = cfg_data;
                    default:                   ;
                endcase
            end
        end
        pending_count = expected_results.size();
    end

endmodule

[tb/ascii_motor_arm_command_decoder_test.sv]
// Testbench top for the ASCII motor/arm command decoder: drives command lines
// under several letter settings and idle patterns, and gives the verdict.
// Depends on amacd_pkg, ascii_motor_arm_command_decoder and amacd_result_checker.
module ascii_motor_arm_command_decoder_test;

    localparam int ArgChars   = 15;
    localparam int CycleLimit = 200000;
    localparam int PhaseBytes = 130;

    logic                                clk;
    logic                                rst_n;
    logic                                cfg_write;
    logic [amacd_pkg::CfgIdxW-1:0]       cfg_index;
    logic [7:0]                          cfg_data;
    logic                                in_valid;
    logic                                in_stall;
    logic [7:0]                          rx_byte;
    logic                                out_valid;
    logic                                out_stall = 1'b0;
    logic [1:0]                          result_kind;
    logic [7:0]                          left_magnitude;
    logic                                left_reverse;
    logic [7:0]                          right_magnitude;
    logic                                right_reverse;
    logic signed [amacd_pkg::AngleW-1:0] waist_target;
    logic signed [amacd_pkg::AngleW-1:0] shoulder_target;
    logic signed [amacd_pkg::AngleW-1:0] elbow_target;
    logic signed [amacd_pkg::AngleW-1:0] wrist_target;
    logic signed [amacd_pkg::AngleW-1:0] gripper_target;
    int                                  mismatch_count;
    int                                  pending_count;

    int         send_idle   = 0;
    int         recv_stall  = 0;
    int         bytes_sent  = 0;
    int         cycle_count = 0;
    logic [7:0] motor_chr;
    logic [7:0] arm_chr;
    logic [7:0] end_chr;

    ascii_motor_arm_command_decoder #(
        .ARG_CHARS(ArgChars)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .rx_byte(rx_byte),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .result_kind(result_kind),
        .left_magnitude(left_magnitude),
        .left_reverse(left_reverse),
        .right_magnitude(right_magnitude),
        .right_reverse(right_reverse),
        .waist_target(waist_target),
        .shoulder_target(shoulder_target),
        .elbow_target(elbow_target),
        .wrist_target(wrist_target),
        .gripper_target(gripper_target)
    );

    amacd_result_checker #(
        .ARG_CHARS(ArgChars)
    ) i_checker (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .rx_byte(rx_byte),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .result_kind(result_kind),
        .left_magnitude(left_magnitude),
        .left_reverse(left_reverse),
        .right_magnitude(right_magnitude),
        .right_reverse(right_reverse),
        .waist_target(waist_target),
        .shoulder_target(shoulder_target),
        .elbow_target(elbow_target),
        .wrist_target(wrist_target),
        .gripper_target(gripper_target),
        .mismatch_count(mismatch_count),
        .pending_count(pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < recv_stall);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit)
        begin
            $display("ascii_motor_arm_command_decoder: mismatch");
            $finish;
        end
    end

    // one request; returns at the falling edge after it was taken
    task automatic send_char(input logic [7:0] c);
        while ($urandom_range(0, 99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= c;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_char(s[i]);
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_count != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic set_letters(input logic [7:0] m, input logic [7:0] a, input logic [7:0] e);
        settle();
        cfg_write <= 1'b1;
        cfg_index <= amacd_pkg::CfgMotorLetter;
        cfg_data  <= m;
        @(negedge clk);
        cfg_index <= amacd_pkg::CfgArmLetter;
        cfg_data  <= a;
        @(negedge clk);
        cfg_index <= amacd_pkg::CfgEndByte;
        cfg_data  <= e;
        @(negedge clk);
        cfg_write <= 1'b0;
        motor_chr = m;
        arm_chr   = a;
        end_chr   = e;
    endtask

    // keep the terminator out of line content
    function automatic logic [7:0] content_char(input logic [7:0] c);
        return (c == end_chr) ? (c ^ 8'h01) : c;
    endfunction

    function automatic logic [7:0] arg_char();
        int         pick;
        logic [7:0] c;
        pick = $urandom_range(0, 99);
        if (pick < 72)
        begin
            c = amacd_pkg::ZeroChr + 8'($urandom_range(0, 9));
        end
        else if (pick < 78)
        begin
            c = amacd_pkg::MinusChr;
        end
        else if (pick < 81)
        begin
            c = amacd_pkg::PlusChr;
        end
        else if (pick < 85)
        begin
            c = 8'($urandom_range(9, 13));
        end
        else if (pick < 88)
        begin
            c = amacd_pkg::NulChr;
        end
        else
        begin
            c = 8'($urandom_range(0, 255));
        end
        return content_char(c);
    endfunction

    task automatic send_arg(input int len);
        repeat (len) send_char(arg_char());
    endtask

    task automatic send_random_line();
        int shape;
        int pick;
        shape = $urandom_range(0, 99);
        if (shape < 10)
        begin
            // raw noise, may hit the terminator early
            repeat ($urandom_range(1, 12)) send_char(8'($urandom_range(0, 255)));
        end
        else
        begin
            repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0)
                send_char(content_char(8'($urandom_range(0, 255))));
            pick = $urandom_range(0, 19);
            if (pick < 9)
            begin
                send_char(motor_chr);
            end
            else if (pick < 18)
            begin
                send_char(arm_chr);
            end
            else if (pick < 19)
            begin
                send_char(content_char(8'($urandom_range(0, 255))));
            end
            if (shape >= 15)
            begin
                send_char(amacd_pkg::SpaceChr);
                send_arg(($urandom_range(0, 4) == 0) ? $urandom_range(0, 4)
                                                     : $urandom_range(5, 19));
                if ($urandom_range(0, 4) != 0)
                begin
                    repeat ($urandom_range(1, 3)) send_char(amacd_pkg::SpaceChr);
                    send_arg($urandom_range(0, 6));
                    if ($urandom_range(0, 5) == 0)
                    begin
                        send_char(amacd_pkg::SpaceChr);
                        send_arg($urandom_range(1, 3));
                    end
                end
            end
        end
        send_char(end_chr);
    endtask

    task automatic run_random(input int budget);
        int stop_at;
        stop_at = bytes_sent + budget;
        while (bytes_sent < stop_at)
        begin
            send_random_line();
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_write = 1'b0;
        cfg_index = amacd_pkg::CfgMotorLetter;
        cfg_data  = '0;
        in_valid  = 1'b0;
        rx_byte   = '0;
        motor_chr = amacd_pkg::MotorLetterRst;
        arm_chr   = amacd_pkg::ArmLetterRst;
        end_chr   = amacd_pkg::EndByteRst;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset letters: several command bytes, saturation, short arm slices, bad letter
        send_text("xo -999 +300v");
        send_text("a 12-4 v");
        send_text("zv");
        run_random(PhaseBytes);

        // zero command byte drives motors on an empty line
        set_letters(8'd0, 8'd255, 8'd255);
        send_idle  = 88;
        recv_stall = 0;
        run_random(PhaseBytes);

        // shared letter, and a space terminator that is checked first
        set_letters("m", "m", amacd_pkg::SpaceChr);
        send_idle  = 0;
        recv_stall = 88;
        run_random(PhaseBytes);

        set_letters(8'd255, 8'd0, amacd_pkg::NulChr);
        send_idle  = 38;
        recv_stall = 38;
        run_random(PhaseBytes);

        // terminator that is also a blank
        set_letters("M", "A", 8'd10);
        send_idle  = 0;
        recv_stall = 0;
        run_random(PhaseBytes);

        settle();
        repeat (8) @(negedge clk);
        if (mismatch_count == 0)
        begin
            $display("ascii_motor_arm_command_decoder: match");
        end
        else
        begin
            $display("ascii_motor_arm_command_decoder: mismatch");
        end
        $finish;
    end

endmodule
